FILE: rtl/cst_pkg.sv
//------------------------------------------------------------------------------
// cst_pkg: shared types and constants of the C subset tokenizer
// Scanner state codes, token kinds and the token record.
//------------------------------------------------------------------------------
package cst_pkg;

    localparam int MaxLexeme = 64;

    // scanner states
    localparam logic [3:0] S_START   = 4'd0;
    localparam logic [3:0] S_IDENT   = 4'd1;
    localparam logic [3:0] S_QOPEN   = 4'd2;
    localparam logic [3:0] S_QLETTER = 4'd3;
    localparam logic [3:0] S_INT     = 4'd4;
    localparam logic [3:0] S_DOT     = 4'd5;
    localparam logic [3:0] S_FRAC    = 4'd6;
    localparam logic [3:0] S_ECHAR   = 4'd7;
    localparam logic [3:0] S_ESIGN   = 4'd8;
    localparam logic [3:0] S_EXPD    = 4'd9;
    localparam logic [3:0] S_SLASH   = 4'd10;
    localparam logic [3:0] S_COMMENT = 4'd11;
    localparam logic [3:0] S_LT      = 4'd12;
    localparam logic [3:0] S_EQ      = 4'd13;
    localparam logic [3:0] S_GT      = 4'd14;
    localparam logic [3:0] S_BANG    = 4'd15;

    // token kinds
    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_KWBASE = 5'd2;
    localparam logic [4:0] K_KWLAST = 5'd10;
    localparam logic [4:0] K_CHAR   = 5'd11;
    localparam logic [4:0] K_INT    = 5'd12;
    localparam logic [4:0] K_FLOAT  = 5'd13;
    localparam logic [4:0] K_EXP    = 5'd14;
    localparam logic [4:0] K_ADD    = 5'd15;
    localparam logic [4:0] K_SUB    = 5'd16;
    localparam logic [4:0] K_MUL    = 5'd17;
    localparam logic [4:0] K_DIV    = 5'd18;
    localparam logic [4:0] K_LT     = 5'd19;
    localparam logic [4:0] K_LE     = 5'd20;
    localparam logic [4:0] K_EQ     = 5'd21;
    localparam logic [4:0] K_ASSIGN = 5'd22;
    localparam logic [4:0] K_GT     = 5'd23;
    localparam logic [4:0] K_GE     = 5'd24;
    localparam logic [4:0] K_NE     = 5'd25;
    localparam logic [4:0] K_SEMI   = 5'd26;
    localparam logic [4:0] K_LPAR   = 5'd27;
    localparam logic [4:0] K_RPAR   = 5'd28;
    localparam logic [4:0] K_LBRACE = 5'd29;
    localparam logic [4:0] K_RBRACE = 5'd30;
    localparam logic [4:0] K_ERROR  = 5'd31;

    // one token, as packed on the output stream (lowest field last here)
    typedef struct packed {
        logic              last_of_run;
        logic              overflow;
        logic [15:0]       line_number;
        logic [6:0]        ident_length;
        logic [7:0]        char_value;
        logic signed [8:0] exponent;
        logic [5:0]        fraction_digits;
        logic [31:0]       mantissa;
        logic [4:0]        token_kind;
    } token_t;

    // keyword spelling, six slots, zero padded
    function automatic logic [47:0] kw_text(input logic [3:0] k);
        logic [47:0] t;
        case (k)
            4'd0:    t = {8'd0, 8'd0, "niam"};
            4'd1:    t = "nruter";
            4'd2:    t = {8'd0, "elihw"};
            4'd3:    t = {32'd0, "fi"};
            4'd4:    t = {16'd0, "esle"};
            4'd5:    t = {24'd0, "tni"};
            4'd6:    t = {8'd0, "taolf"};
            4'd7:    t = {16'd0, "rahc"};
            4'd8:    t = {16'd0, "diov"};
            default: t = '1;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] n;
        case (k)
            4'd0: n = 3'd4;
            4'd1: n = 3'd6;
            4'd2: n = 3'd5;
            4'd3: n = 3'd2;
            4'd4: n = 3'd4;
            4'd5: n = 3'd3;
            4'd6: n = 3'd5;
            4'd7: n = 3'd4;
            4'd8: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/cst_scan.sv
//------------------------------------------------------------------------------
// cst_scan: scanner state and token emission
// Holds the scan state and accumulators; per byte gives up to two tokens.
//------------------------------------------------------------------------------
module cst_scan #(
    parameter int MAX_LEXEME = cst_pkg::MaxLexeme
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,          // one byte taken this cycle
    input  logic [7:0]       char_code,
    input  logic             end_of_input,
    output logic [1:0]       tok_count,
    output cst_pkg::token_t  tok0,
    output cst_pkg::token_t  tok1
);

    localparam int LenCap = (MAX_LEXEME < 127) ? MAX_LEXEME : 127;

    typedef struct packed {
        logic [3:0]  st;
        logic [47:0] kw;
        logic [6:0]  len;
        logic [31:0] man;
        logic [5:0]  frac;
        logic [7:0]  ex;
        logic        neg;
        logic [7:0]  lit;
        logic        ovf;
        logic [15:0] line;
    } scan_t;

    // start state, empty token, line counter at one
    localparam scan_t ScanReset = {115'd0, 16'd1};

    scan_t st_reg;
    scan_t st_next;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic scan_t clear_tok(input scan_t s);
        scan_t r;
        r = s;
        r.kw = '0; r.len = '0; r.man = '0; r.frac = '0;
        r.ex = '0; r.neg = 1'b0; r.lit = '0; r.ovf = 1'b0;
        return r;
    endfunction

    function automatic scan_t add_digit(input scan_t s, input logic [7:0] c);
        scan_t r;
        logic [35:0] v;
        r = s;
        v = {4'd0, s.man} * 36'd10 + {32'd0, c[3:0]};
        if (v[35:32] != 4'd0) begin
            r.man = '1;
            r.ovf = 1'b1;
        end else begin
            r.man = v[31:0];
        end
        return r;
    endfunction

    function automatic scan_t add_frac(input scan_t s, input logic [7:0] c);
        scan_t r;
        r = add_digit(s, c);
        if (s.frac == 6'd63) r.ovf = 1'b1;
        else r.frac = s.frac + 6'd1;
        return r;
    endfunction

    function automatic scan_t add_exp(input scan_t s, input logic [7:0] c);
        scan_t r;
        logic [11:0] v;
        r = s;
        v = {4'd0, s.ex} * 12'd10 + {8'd0, c[3:0]};
        if (v > 12'd255) begin
            r.ex = 8'd255;
            r.ovf = 1'b1;
        end else begin
            r.ex = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] inc_line(input logic [15:0] l);
        return (l == 16'hFFFF) ? l : l + 16'd1;
    endfunction

    // keyword or identifier kind
    function automatic logic [4:0] word_kind(input scan_t s);
        logic [4:0] k;
        k = cst_pkg::K_IDENT;
        for (int i = 8; i >= 0; i--) begin
            if (s.len == {4'd0, cst_pkg::kw_len(4'(i))} && s.kw == cst_pkg::kw_text(4'(i)))
                k = cst_pkg::K_KWBASE + 5'(i);
        end
        return k;
    endfunction

    // token record from current accumulators
    function automatic cst_pkg::token_t make_tok(input scan_t s, input logic [4:0] k);
        cst_pkg::token_t t;
        t = '0;
        t.token_kind = k;
        if (k >= cst_pkg::K_INT && k <= cst_pkg::K_EXP) begin
            t.mantissa = s.man;
            if (k != cst_pkg::K_INT) t.fraction_digits = s.frac;
            if (k == cst_pkg::K_EXP)
                t.exponent = s.neg ? -$signed({1'b0, s.ex}) : $signed({1'b0, s.ex});
            t.overflow = s.ovf;
        end else if (k == cst_pkg::K_CHAR) begin
            t.char_value = s.lit;
        end else if (k >= cst_pkg::K_IDENT && k <= cst_pkg::K_KWLAST) begin
            t.ident_length = s.len;
            t.overflow = s.ovf;
        end
        t.line_number = s.line;
        return t;
    endfunction

    // next state for one byte: end-of-input flush, pending token or start state; emit flags and kinds
    always_comb
    begin
        scan_t s;
        scan_t a;
        logic [7:0] c;
        logic e1, e2, consumed;
        logic [4:0] k1, k2;
        cst_pkg::token_t t1, t2;

        c = char_code;
        s = st_reg;
        e1 = 1'b0; e2 = 1'b0; consumed = 1'b1;
        k1 = cst_pkg::K_ERROR; k2 = cst_pkg::K_ERROR;
        t1 = '0; t2 = '0;
        a = s;

        if (end_of_input) begin
            // flush pending token, then emit the end token
            e1 = 1'b1;
            case (s.st)
                cst_pkg::S_IDENT: k1 = word_kind(s);
                cst_pkg::S_INT:   k1 = cst_pkg::K_INT;
                cst_pkg::S_FRAC:  k1 = cst_pkg::K_FLOAT;
                cst_pkg::S_EXPD:  k1 = cst_pkg::K_EXP;
                cst_pkg::S_SLASH: k1 = cst_pkg::K_DIV;
                cst_pkg::S_LT:    k1 = cst_pkg::K_LT;
                cst_pkg::S_EQ:    k1 = cst_pkg::K_ASSIGN;
                cst_pkg::S_GT:    k1 = cst_pkg::K_GT;
                cst_pkg::S_START, cst_pkg::S_COMMENT: e1 = 1'b0;
                default:          k1 = cst_pkg::K_ERROR;
            endcase
            t1 = make_tok(s, k1);
            a = clear_tok(s);
            a.st = cst_pkg::S_START;
            e2 = 1'b1;
            k2 = cst_pkg::K_END;
            t2 = make_tok(a, k2);
        end else begin
            // continue pending token
            case (s.st)
                cst_pkg::S_IDENT:
                    if (is_alpha(c) || is_digit(c)) begin
                        case (s.len)
                            7'd0: a.kw[7:0]   = c;
                            7'd1: a.kw[15:8]  = c;
                            7'd2: a.kw[23:16] = c;
                            7'd3: a.kw[31:24] = c;
                            7'd4: a.kw[39:32] = c;
                            7'd5: a.kw[47:40] = c;
                            default: ;
                        endcase
                        if (s.len >= 7'(LenCap)) a.ovf = 1'b1;
                        else a.len = s.len + 7'd1;
                    end else begin
                        e1 = 1'b1; k1 = word_kind(s); consumed = 1'b0;
                    end
                cst_pkg::S_QOPEN:
                    if (is_alpha(c)) begin
                        a.lit = c; a.st = cst_pkg::S_QLETTER;
                    end else begin
                        e1 = 1'b1; consumed = 1'b0;
                    end
                cst_pkg::S_QLETTER:
                    begin
                        e1 = 1'b1;
                        if (c == 8'h27) k1 = cst_pkg::K_CHAR;
                        else consumed = 1'b0;
                    end
                cst_pkg::S_INT:
                    if (is_digit(c)) a = add_digit(s, c);
                    else if (c == ".") a.st = cst_pkg::S_DOT;
                    else begin
                        e1 = 1'b1; k1 = cst_pkg::K_INT; consumed = 1'b0;
                    end
                cst_pkg::S_DOT:
                    if (is_digit(c)) begin
                        a = add_frac(s, c); a.st = cst_pkg::S_FRAC;
                    end else begin
                        e1 = 1'b1; consumed = 1'b0;
                    end
                cst_pkg::S_FRAC:
                    if (is_digit(c)) a = add_frac(s, c);
                    else if (c == "E") a.st = cst_pkg::S_ECHAR;
                    else begin
                        e1 = 1'b1; k1 = cst_pkg::K_FLOAT; consumed = 1'b0;
                    end
                cst_pkg::S_ECHAR:
                    if (c == "+" || c == "-") begin
                        a.neg = (c == "-"); a.st = cst_pkg::S_ESIGN;
                    end else begin
                        e1 = 1'b1; consumed = 1'b0;
                    end
                cst_pkg::S_ESIGN:
                    if (is_digit(c)) begin
                        a = add_exp(s, c); a.st = cst_pkg::S_EXPD;
                    end else begin
                        e1 = 1'b1; consumed = 1'b0;
                    end
                cst_pkg::S_EXPD:
                    if (is_digit(c)) a = add_exp(s, c);
                    else begin
                        e1 = 1'b1; k1 = cst_pkg::K_EXP; consumed = 1'b0;
                    end
                cst_pkg::S_SLASH:
                    if (c == "/") a.st = cst_pkg::S_COMMENT;
                    else begin
                        e1 = 1'b1; k1 = cst_pkg::K_DIV; consumed = 1'b0;
                    end
                cst_pkg::S_COMMENT:
                    if (c == 8'h0A) begin
                        a.line = inc_line(s.line); a.st = cst_pkg::S_START;
                    end
                cst_pkg::S_LT:
                    begin
                        e1 = 1'b1;
                        if (c == "=") k1 = cst_pkg::K_LE;
                        else begin k1 = cst_pkg::K_LT; consumed = 1'b0; end
                    end
                cst_pkg::S_EQ:
                    begin
                        e1 = 1'b1;
                        if (c == "=") k1 = cst_pkg::K_EQ;
                        else begin k1 = cst_pkg::K_ASSIGN; consumed = 1'b0; end
                    end
                cst_pkg::S_GT:
                    begin
                        e1 = 1'b1;
                        if (c == "=") k1 = cst_pkg::K_GE;
                        else begin k1 = cst_pkg::K_GT; consumed = 1'b0; end
                    end
                cst_pkg::S_BANG:
                    begin
                        e1 = 1'b1;
                        if (c == "=") k1 = cst_pkg::K_NE;
                        else consumed = 1'b0;
                    end
                default:
                    consumed = 1'b0;
            endcase

            if (e1) begin
                t1 = make_tok(s, k1);
                a.st = cst_pkg::S_START;
            end

            // byte processed from the start state
            if (!consumed) begin
                a = clear_tok(a);
                a.st = cst_pkg::S_START;
                if (c == " " || c == 8'h09) begin
                end else if (c == 8'h0A) begin
                    a.line = inc_line(a.line);
                end else if (is_alpha(c)) begin
                    a.kw[7:0] = c; a.len = 7'd1; a.st = cst_pkg::S_IDENT;
                end else if (is_digit(c)) begin
                    a = add_digit(a, c); a.st = cst_pkg::S_INT;
                end else begin
                    e2 = 1'b1;
                    case (c)
                        8'h27: begin e2 = 1'b0; a.st = cst_pkg::S_QOPEN; end
                        "+": k2 = cst_pkg::K_ADD;
                        "-": k2 = cst_pkg::K_SUB;
                        "*": k2 = cst_pkg::K_MUL;
                        "/": begin e2 = 1'b0; a.st = cst_pkg::S_SLASH; end
                        "<": begin e2 = 1'b0; a.st = cst_pkg::S_LT; end
                        "=": begin e2 = 1'b0; a.st = cst_pkg::S_EQ; end
                        ">": begin e2 = 1'b0; a.st = cst_pkg::S_GT; end
                        "!": begin e2 = 1'b0; a.st = cst_pkg::S_BANG; end
                        ";": k2 = cst_pkg::K_SEMI;
                        "(": k2 = cst_pkg::K_LPAR;
                        ")": k2 = cst_pkg::K_RPAR;
                        "{": k2 = cst_pkg::K_LBRACE;
                        "}": k2 = cst_pkg::K_RBRACE;
                        default: k2 = cst_pkg::K_ERROR;
                    endcase
                    t2 = make_tok(a, k2);
                end
            end
        end

        st_next = a;

        // compact tokens, mark the last one
        if (e1 && e2) begin
            tok_count = 2'd2;
            tok0 = t1;
            tok1 = t2;
            tok1.last_of_run = 1'b1;
        end else if (e1 || e2) begin
            tok_count = 2'd1;
            tok0 = e1 ? t1 : t2;
            tok0.last_of_run = 1'b1;
            tok1 = t2;
        end else begin
            tok_count = 2'd0;
            tok0 = t1;
            tok1 = t2;
        end
    end

    // scanner state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= ScanReset;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/cst_outq.sv
//------------------------------------------------------------------------------
// cst_outq: token output queue
// Takes up to two tokens per cycle, hands out one per transaction.
//------------------------------------------------------------------------------
module cst_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  cst_pkg::token_t  push0,
    input  cst_pkg::token_t  push1,
    output logic [2:0]       fill,
    output logic             out_valid,
    input  logic             out_ready,
    output cst_pkg::token_t  out_tok
);

    // four-entry circular buffer
    cst_pkg::token_t buf_reg [4];
    logic [1:0] rd_reg;
    logic [1:0] wr_reg;
    logic [2:0] fill_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = fill_reg != 3'd0;
    assign out_tok   = buf_reg[rd_reg];
    assign fill      = fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end else begin
            rd_reg   <= rd_reg + {1'b0, pop};
            wr_reg   <= wr_reg + push_count;
            fill_reg <= fill_reg + {1'b0, push_count} - {2'b0, pop};
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) buf_reg[wr_reg] <= push0;
        if (push_count == 2'd2) buf_reg[wr_reg + 2'd1] <= push1;
    end

endmodule

FILE: rtl/c_subset_tokenizer.sv
//------------------------------------------------------------------------------
// c_subset_tokenizer: streaming lexer for a small C subset
// Output: each token is written into the token queue and presented from there.
// Throughput: one byte per cycle; up to two tokens per byte, queued.
// Input stalls only when the four-entry token queue could overflow.
// Reset: scanner at start state, line counter at one, queue empty.
//------------------------------------------------------------------------------
module c_subset_tokenizer #(
    parameter int MAX_LEXEME = cst_pkg::MaxLexeme
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // mantissa[31:0], fraction_digits[37:32],
                                   // exponent[46:38], char_value[54:47],
                                   // ident_length[61:55], line_number[77:62],
                                   // overflow[78]
    output logic [4:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_of_run
);

    logic [1:0]      tok_count;
    cst_pkg::token_t tok0;
    cst_pkg::token_t tok1;
    cst_pkg::token_t out_tok;
    logic [2:0]      fill;
    logic            step;

    // at most two entries queued leaves room for two more
    assign s_tready = fill <= 3'd2;
    assign step     = s_tvalid && s_tready;

    cst_scan #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .tok_count    (tok_count),
        .tok0         (tok0),
        .tok1         (tok1)
    );

    cst_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (step ? tok_count : 2'd0),
        .push0      (tok0),
        .push1      (tok1),
        .fill       (fill),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tok    (out_tok)
    );

    assign m_tdata  = {1'b0, out_tok.overflow, out_tok.line_number, out_tok.ident_length,
                       out_tok.char_value, out_tok.exponent,
                       out_tok.fraction_digits, out_tok.mantissa};
    assign m_tuser  = out_tok.token_kind;
    assign m_tlast  = out_tok.last_of_run;

endmodule
